FILE: hdl/limit_cycle_min_cost_switch_select_macros.svh
// assertion macros used by the port-level checker
`ifndef LIMIT_CYCLE_MIN_COST_SWITCH_SELECT_MACROS_SVH
`define LIMIT_CYCLE_MIN_COST_SWITCH_SELECT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define LCMCSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define LCMCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lcmcss_pkg.sv
// shared types, constants, arithmetic helpers and micro-program of the switch selector
package lcmcss_pkg;

    localparam int MAX_SUBSYSTEMS  = 8;
    localparam int MAX_CYCLE_STEPS = 16;
    localparam int STATE_ORDER     = 2;

    localparam int SUB_W   = $clog2(MAX_SUBSYSTEMS);
    localparam int STEP_W  = $clog2(MAX_CYCLE_STEPS);
    localparam int NSUB_W  = 4;
    localparam int LEN_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 72;

    localparam int MAT_DEPTH  = (1 << SUB_W) * 4;
    localparam int P_DEPTH    = (1 << STEP_W) * 4;
    localparam int XE_DEPTH   = (1 << STEP_W) * STATE_ORDER;
    localparam int ELL_DEPTH  = (1 << STEP_W) * (1 << SUB_W) * STATE_ORDER;

    localparam int SLOTS    = 46;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int PC_W     = 7;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [PC_W-1:0]   pc_t;

    // table selector codes of a load beat
    typedef enum logic [2:0] {
        TBL_A   = 3'd0,
        TBL_E   = 3'd1,
        TBL_P   = 3'd2,
        TBL_XE  = 3'd3,
        TBL_ELL = 3'd4
    } tbl_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SUBSYSTEMS = 2'd0,
        CFG_CYCLE_LENGTH   = 2'd1
    } cfg_reg_t;

    // micro-op kinds
    typedef enum logic [2:0] {
        UOP_LD  = 3'd0,
        UOP_LX  = 3'd1,
        UOP_MAC = 3'd2,
        UOP_ADD = 3'd3,
        UOP_SUB = 3'd4,
        UOP_ST  = 3'd5,
        UOP_END = 3'd6
    } uop_kind_t;

    // table operand sources
    typedef enum logic [2:0] {
        SRC_A   = 3'd0,
        SRC_E   = 3'd1,
        SRC_PN  = 3'd2,
        SRC_PC  = 3'd3,
        SRC_ELL = 3'd4
    } src_t;

    typedef struct packed {
        uop_kind_t   kind;
        src_t        src;
        logic [1:0]  el;
        logic        clr;
        slot_t       ra;
        slot_t       rb;
        slot_t       dst;
    } uop_t;

    typedef enum logic [2:0] {
        SQ_IDLE  = 3'd0,
        SQ_MOD   = 3'd1,
        SQ_FETCH = 3'd2,
        SQ_EXEC  = 3'd3,
        SQ_MULW  = 3'd4,
        SQ_DONE  = 3'd5
    } seq_state_t;

    typedef enum logic [1:0] {
        MS_IDLE = 2'd0,
        MS_PART = 2'd1,
        MS_NEG  = 2'd2,
        MS_DONE = 2'd3
    } mul_state_t;

    // scratch slot map
    localparam slot_t SL_A  = 6'd0;
    localparam slot_t SL_E  = 6'd4;
    localparam slot_t SL_PN = 6'd8;
    localparam slot_t SL_PC = 6'd12;
    localparam slot_t SL_L  = 6'd16;
    localparam slot_t SL_XI = 6'd18;
    localparam slot_t SL_T1 = 6'd20;
    localparam slot_t SL_T2 = 6'd24;
    localparam slot_t SL_EE = 6'd28;
    localparam slot_t SL_M  = 6'd32;
    localparam slot_t SL_Q  = 6'd36;
    localparam slot_t SL_S  = 6'd38;
    localparam slot_t SL_R  = 6'd40;
    localparam slot_t SL_C  = 6'd42;
    localparam slot_t SL_F0 = 6'd43;
    localparam slot_t SL_F1 = 6'd44;
    localparam slot_t SL_F2 = 6'd45;

    localparam pc_t BODY_START = 7'd2;

    // saturating 64-bit add
    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // saturating 64-bit subtract
    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic uop_t u_ld(src_t s, logic [1:0] el, slot_t d);
        uop_t u;
        u = '0;
        u.kind = UOP_LD;
        u.src  = s;
        u.el   = el;
        u.dst  = d;
        return u;
    endfunction

    function automatic uop_t u_lx(logic [1:0] el, slot_t d);
        uop_t u;
        u = '0;
        u.kind = UOP_LX;
        u.el   = el;
        u.dst  = d;
        return u;
    endfunction

    function automatic uop_t u_mac(slot_t a, slot_t b, logic c);
        uop_t u;
        u = '0;
        u.kind = UOP_MAC;
        u.ra   = a;
        u.rb   = b;
        u.clr  = c;
        return u;
    endfunction

    function automatic uop_t u_add(slot_t a, logic c);
        uop_t u;
        u = '0;
        u.kind = UOP_ADD;
        u.ra   = a;
        u.clr  = c;
        return u;
    endfunction

    function automatic uop_t u_sub(slot_t a);
        uop_t u;
        u = '0;
        u.kind = UOP_SUB;
        u.ra   = a;
        return u;
    endfunction

    function automatic uop_t u_st(slot_t d);
        uop_t u;
        u = '0;
        u.kind = UOP_ST;
        u.dst  = d;
        return u;
    endfunction

    function automatic uop_t u_end();
        uop_t u;
        u = '0;
        u.kind = UOP_END;
        return u;
    endfunction

    // micro-program: prologue forms xi, body evaluates one subsystem cost
    function automatic uop_t prog_at(pc_t pc);
        uop_t u;
        u = u_end();
        case (pc)
            7'd0:   u = u_lx(2'd0, SL_XI);
            7'd1:   u = u_lx(2'd1, SL_XI + 6'd1);
            7'd2:   u = u_ld(SRC_A, 2'd0, SL_A);
            7'd3:   u = u_ld(SRC_A, 2'd1, SL_A + 6'd1);
            7'd4:   u = u_ld(SRC_A, 2'd2, SL_A + 6'd2);
            7'd5:   u = u_ld(SRC_A, 2'd3, SL_A + 6'd3);
            7'd6:   u = u_ld(SRC_E, 2'd0, SL_E);
            7'd7:   u = u_ld(SRC_E, 2'd1, SL_E + 6'd1);
            7'd8:   u = u_ld(SRC_E, 2'd2, SL_E + 6'd2);
            7'd9:   u = u_ld(SRC_E, 2'd3, SL_E + 6'd3);
            7'd10:  u = u_ld(SRC_PN, 2'd0, SL_PN);
            7'd11:  u = u_ld(SRC_PN, 2'd1, SL_PN + 6'd1);
            7'd12:  u = u_ld(SRC_PN, 2'd2, SL_PN + 6'd2);
            7'd13:  u = u_ld(SRC_PN, 2'd3, SL_PN + 6'd3);
            7'd14:  u = u_ld(SRC_PC, 2'd0, SL_PC);
            7'd15:  u = u_ld(SRC_PC, 2'd1, SL_PC + 6'd1);
            7'd16:  u = u_ld(SRC_PC, 2'd2, SL_PC + 6'd2);
            7'd17:  u = u_ld(SRC_PC, 2'd3, SL_PC + 6'd3);
            7'd18:  u = u_ld(SRC_ELL, 2'd0, SL_L);
            7'd19:  u = u_ld(SRC_ELL, 2'd1, SL_L + 6'd1);
            // t1 = A' P[n]
            7'd20:  u = u_mac(SL_A, SL_PN, 1'b1);
            7'd21:  u = u_mac(SL_A + 6'd2, SL_PN + 6'd2, 1'b0);
            7'd22:  u = u_st(SL_T1);
            7'd23:  u = u_mac(SL_A, SL_PN + 6'd1, 1'b1);
            7'd24:  u = u_mac(SL_A + 6'd2, SL_PN + 6'd3, 1'b0);
            7'd25:  u = u_st(SL_T1 + 6'd1);
            7'd26:  u = u_mac(SL_A + 6'd1, SL_PN, 1'b1);
            7'd27:  u = u_mac(SL_A + 6'd3, SL_PN + 6'd2, 1'b0);
            7'd28:  u = u_st(SL_T1 + 6'd2);
            7'd29:  u = u_mac(SL_A + 6'd1, SL_PN + 6'd1, 1'b1);
            7'd30:  u = u_mac(SL_A + 6'd3, SL_PN + 6'd3, 1'b0);
            7'd31:  u = u_st(SL_T1 + 6'd3);
            // t2 = t1 A
            7'd32:  u = u_mac(SL_T1, SL_A, 1'b1);
            7'd33:  u = u_mac(SL_T1 + 6'd1, SL_A + 6'd2, 1'b0);
            7'd34:  u = u_st(SL_T2);
            7'd35:  u = u_mac(SL_T1, SL_A + 6'd1, 1'b1);
            7'd36:  u = u_mac(SL_T1 + 6'd1, SL_A + 6'd3, 1'b0);
            7'd37:  u = u_st(SL_T2 + 6'd1);
            7'd38:  u = u_mac(SL_T1 + 6'd2, SL_A, 1'b1);
            7'd39:  u = u_mac(SL_T1 + 6'd3, SL_A + 6'd2, 1'b0);
            7'd40:  u = u_st(SL_T2 + 6'd2);
            7'd41:  u = u_mac(SL_T1 + 6'd2, SL_A + 6'd1, 1'b1);
            7'd42:  u = u_mac(SL_T1 + 6'd3, SL_A + 6'd3, 1'b0);
            7'd43:  u = u_st(SL_T2 + 6'd3);
            // ee = E' E
            7'd44:  u = u_mac(SL_E, SL_E, 1'b1);
            7'd45:  u = u_mac(SL_E + 6'd2, SL_E + 6'd2, 1'b0);
            7'd46:  u = u_st(SL_EE);
            7'd47:  u = u_mac(SL_E, SL_E + 6'd1, 1'b1);
            7'd48:  u = u_mac(SL_E + 6'd2, SL_E + 6'd3, 1'b0);
            7'd49:  u = u_st(SL_EE + 6'd1);
            7'd50:  u = u_mac(SL_E + 6'd1, SL_E, 1'b1);
            7'd51:  u = u_mac(SL_E + 6'd3, SL_E + 6'd2, 1'b0);
            7'd52:  u = u_st(SL_EE + 6'd2);
            7'd53:  u = u_mac(SL_E + 6'd1, SL_E + 6'd1, 1'b1);
            7'd54:  u = u_mac(SL_E + 6'd3, SL_E + 6'd3, 1'b0);
            7'd55:  u = u_st(SL_EE + 6'd3);
            // m = t2 - P[k] + ee
            7'd56:  u = u_add(SL_T2, 1'b1);
            7'd57:  u = u_sub(SL_PC);
            7'd58:  u = u_add(SL_EE, 1'b0);
            7'd59:  u = u_st(SL_M);
            7'd60:  u = u_add(SL_T2 + 6'd1, 1'b1);
            7'd61:  u = u_sub(SL_PC + 6'd1);
            7'd62:  u = u_add(SL_EE + 6'd1, 1'b0);
            7'd63:  u = u_st(SL_M + 6'd1);
            7'd64:  u = u_add(SL_T2 + 6'd2, 1'b1);
            7'd65:  u = u_sub(SL_PC + 6'd2);
            7'd66:  u = u_add(SL_EE + 6'd2, 1'b0);
            7'd67:  u = u_st(SL_M + 6'd2);
            7'd68:  u = u_add(SL_T2 + 6'd3, 1'b1);
            7'd69:  u = u_sub(SL_PC + 6'd3);
            7'd70:  u = u_add(SL_EE + 6'd3, 1'b0);
            7'd71:  u = u_st(SL_M + 6'd3);
            // q = t1 ell
            7'd72:  u = u_mac(SL_T1, SL_L, 1'b1);
            7'd73:  u = u_mac(SL_T1 + 6'd1, SL_L + 6'd1, 1'b0);
            7'd74:  u = u_st(SL_Q);
            7'd75:  u = u_mac(SL_T1 + 6'd2, SL_L, 1'b1);
            7'd76:  u = u_mac(SL_T1 + 6'd3, SL_L + 6'd1, 1'b0);
            7'd77:  u = u_st(SL_Q + 6'd1);
            // s = ell' P[n]
            7'd78:  u = u_mac(SL_L, SL_PN, 1'b1);
            7'd79:  u = u_mac(SL_L + 6'd1, SL_PN + 6'd2, 1'b0);
            7'd80:  u = u_st(SL_S);
            7'd81:  u = u_mac(SL_L, SL_PN + 6'd1, 1'b1);
            7'd82:  u = u_mac(SL_L + 6'd1, SL_PN + 6'd3, 1'b0);
            7'd83:  u = u_st(SL_S + 6'd1);
            // r = s A, c = s ell
            7'd84:  u = u_mac(SL_S, SL_A, 1'b1);
            7'd85:  u = u_mac(SL_S + 6'd1, SL_A + 6'd2, 1'b0);
            7'd86:  u = u_st(SL_R);
            7'd87:  u = u_mac(SL_S, SL_A + 6'd1, 1'b1);
            7'd88:  u = u_mac(SL_S + 6'd1, SL_A + 6'd3, 1'b0);
            7'd89:  u = u_st(SL_R + 6'd1);
            7'd90:  u = u_mac(SL_S, SL_L, 1'b1);
            7'd91:  u = u_mac(SL_S + 6'd1, SL_L + 6'd1, 1'b0);
            7'd92:  u = u_st(SL_C);
            // f0, f1, f2
            7'd93:  u = u_mac(SL_XI, SL_M, 1'b1);
            7'd94:  u = u_mac(SL_XI + 6'd1, SL_M + 6'd2, 1'b0);
            7'd95:  u = u_add(SL_R, 1'b0);
            7'd96:  u = u_st(SL_F0);
            7'd97:  u = u_mac(SL_XI, SL_M + 6'd1, 1'b1);
            7'd98:  u = u_mac(SL_XI + 6'd1, SL_M + 6'd3, 1'b0);
            7'd99:  u = u_add(SL_R + 6'd1, 1'b0);
            7'd100: u = u_st(SL_F1);
            7'd101: u = u_mac(SL_XI, SL_Q, 1'b1);
            7'd102: u = u_mac(SL_XI + 6'd1, SL_Q + 6'd1, 1'b0);
            7'd103: u = u_add(SL_C, 1'b0);
            7'd104: u = u_st(SL_F2);
            // cost
            7'd105: u = u_mac(SL_F0, SL_XI, 1'b1);
            7'd106: u = u_mac(SL_F1, SL_XI + 6'd1, 1'b0);
            7'd107: u = u_add(SL_F2, 1'b0);
            default: u = u_end();
        endcase
        return u;
    endfunction

endpackage

FILE: hdl/lcmcss_qmul.sv
// multi-cycle Q48.16 multiplier: four 32x32 partial products, floor shift, saturation
module lcmcss_qmul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    output logic               done,
    output logic signed [63:0] result
);

    lcmcss_pkg::mul_state_t state_reg, state_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [63:0]  mag_a_reg, mag_a_next;
    logic [63:0]  mag_b_reg, mag_b_next;
    logic         neg_reg, neg_next;
    logic [127:0] prod_reg, prod_next;

    logic [31:0]  half_a, half_b;
    logic [63:0]  pp;
    logic [1:0]   sh;
    logic         fits;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcmcss_pkg::MS_IDLE;
            cnt_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // operand and product registers
    always_ff @(posedge aclk) begin
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcmcss_pkg::MS_IDLE: if (start) state_next = lcmcss_pkg::MS_PART;
            lcmcss_pkg::MS_PART: if (cnt_reg == 2'd3) state_next = lcmcss_pkg::MS_NEG;
            lcmcss_pkg::MS_NEG:  state_next = lcmcss_pkg::MS_DONE;
            lcmcss_pkg::MS_DONE: state_next = lcmcss_pkg::MS_IDLE;
            default:             state_next = lcmcss_pkg::MS_IDLE;
        endcase
    end

    // partial product selection
    always_comb begin
        half_a = cnt_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
        half_b = cnt_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
        pp     = half_a * half_b;
        sh     = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
    end

    // datapath
    always_comb begin
        cnt_next   = cnt_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        done       = 1'b0;
        case (state_reg)
            lcmcss_pkg::MS_IDLE: begin
                if (start) begin
                    mag_a_next = op_a[63] ? (64'd0 - op_a) : op_a;
                    mag_b_next = op_b[63] ? (64'd0 - op_b) : op_b;
                    neg_next   = op_a[63] ^ op_b[63];
                    prod_next  = 128'd0;
                    cnt_next   = 2'd0;
                end
            end
            lcmcss_pkg::MS_PART: begin
                prod_next = prod_reg + ({64'd0, pp} << {sh, 5'd0});
                cnt_next  = cnt_reg + 2'd1;
            end
            lcmcss_pkg::MS_NEG: begin
                if (neg_reg) prod_next = 128'd0 - prod_reg;
            end
            lcmcss_pkg::MS_DONE: done = 1'b1;
            default: done = 1'b0;
        endcase
    end

    // floor shift by 16 and saturate to 64 bits
    always_comb begin
        fits = (&prod_reg[127:79]) | ~(|prod_reg[127:79]);
        if (fits)
            result = prod_reg[79:16];
        else
            result = prod_reg[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end

endmodule

FILE: hdl/limit_cycle_min_cost_switch_select.sv
// Limit-cycle minimum-cost switch selector. Load beats (tuser low) write one
// table word and are taken back to back. A sample beat (tuser high) is run by
// a micro-sequencer over one shared multi-cycle Q48.16 multiplier: the next
// step index is first reduced by repeated subtraction, then each subsystem
// takes 46 multiplies plus table and scratch moves. The block takes no beat
// while a sample is in work; the result register lets the next beat in while
// the last result waits.
module limit_cycle_min_cost_switch_select (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample / load channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // table_select, entry_index, sub_index, element, load_value,
    // state_first, state_second, zero pad
    input  logic [lcmcss_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind
    input  logic                                s_tuser,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // chosen_subsystem, best_cost, step_used, zero pad
    output logic [lcmcss_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcmcss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcmcss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SUB_W  = lcmcss_pkg::SUB_W;
    localparam int STEP_W = lcmcss_pkg::STEP_W;

    // input fields
    logic [2:0]         in_sel;
    logic [3:0]         in_ent;
    logic [2:0]         in_sub;
    logic [1:0]         in_el;
    logic [31:0]        in_val;
    logic [31:0]        in_x0, in_x1;

    assign in_sel = s_tdata[2:0];
    assign in_ent = s_tdata[6:3];
    assign in_sub = s_tdata[9:7];
    assign in_el  = s_tdata[11:10];
    assign in_val = s_tdata[43:12];
    assign in_x0  = s_tdata[75:44];
    assign in_x1  = s_tdata[107:76];

    // configuration
    logic [lcmcss_pkg::NSUB_W-1:0] nsub_reg;
    logic [lcmcss_pkg::LEN_W-1:0]  len_reg;
    logic [lcmcss_pkg::NSUB_W-1:0] nsub_eff;
    logic [lcmcss_pkg::LEN_W-1:0]  len_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nsub_reg <= 4'd1;
            len_reg  <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcmcss_pkg::CFG_NUM_SUBSYSTEMS:
                    nsub_reg <= cfg_data[lcmcss_pkg::NSUB_W-1:0];
                lcmcss_pkg::CFG_CYCLE_LENGTH:
                    len_reg  <= cfg_data[lcmcss_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp register values into range
    always_comb begin
        nsub_eff = nsub_reg;
        if (nsub_reg == '0) nsub_eff = 4'd1;
        else if (nsub_reg > 4'(lcmcss_pkg::MAX_SUBSYSTEMS))
            nsub_eff = 4'(lcmcss_pkg::MAX_SUBSYSTEMS);
        len_eff = len_reg;
        if (len_reg == '0) len_eff = 5'd1;
        else if (len_reg > 5'(lcmcss_pkg::MAX_CYCLE_STEPS))
            len_eff = 5'(lcmcss_pkg::MAX_CYCLE_STEPS);
    end

    // coefficient memories
    logic [31:0] a_mem   [lcmcss_pkg::MAT_DEPTH];
    logic [31:0] e_mem   [lcmcss_pkg::MAT_DEPTH];
    logic [31:0] p_mem   [lcmcss_pkg::P_DEPTH];
    logic [31:0] xe_mem  [lcmcss_pkg::XE_DEPTH];
    logic [31:0] ell_mem [lcmcss_pkg::ELL_DEPTH];

    logic load_beat;
    logic ent_sub_ok, ent_step_ok, sub_ok;

    assign load_beat   = s_tvalid && s_tready && !s_tuser;
    assign ent_sub_ok  = {1'b0, in_ent} < 5'(lcmcss_pkg::MAX_SUBSYSTEMS);
    assign ent_step_ok = {1'b0, in_ent} < 5'(lcmcss_pkg::MAX_CYCLE_STEPS);
    assign sub_ok      = {1'b0, in_sub} < 4'(lcmcss_pkg::MAX_SUBSYSTEMS);

    // table writes on load beats
    always_ff @(posedge aclk) begin
        if (load_beat) begin
            case (in_sel)
                lcmcss_pkg::TBL_A:
                    if (ent_sub_ok) a_mem[{in_ent[SUB_W-1:0], in_el}] <= in_val;
                lcmcss_pkg::TBL_E:
                    if (ent_sub_ok) e_mem[{in_ent[SUB_W-1:0], in_el}] <= in_val;
                lcmcss_pkg::TBL_P:
                    if (ent_step_ok) p_mem[{in_ent[STEP_W-1:0], in_el}] <= in_val;
                lcmcss_pkg::TBL_XE:
                    if (ent_step_ok && !in_el[1])
                        xe_mem[{in_ent[STEP_W-1:0], in_el[0]}] <= in_val;
                lcmcss_pkg::TBL_ELL:
                    if (ent_step_ok && sub_ok && !in_el[1])
                        ell_mem[{in_ent[STEP_W-1:0], in_sub[SUB_W-1:0], in_el[0]}]
                            <= in_val;
                default: ;
            endcase
        end
    end

    // sequencer registers
    lcmcss_pkg::seq_state_t state_reg, state_next;
    lcmcss_pkg::pc_t        pc_reg, pc_next;
    logic [SUB_W-1:0]       sub_reg, sub_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [STEP_W-1:0]      k_reg, k_next;
    logic [lcmcss_pkg::LEN_W-1:0] n_reg, n_next;
    logic [31:0]            x0_reg, x0_next, x1_reg, x1_next;
    logic signed [63:0]     acc_reg, acc_next;
    logic signed [63:0]     best_reg, best_next;
    logic [SUB_W-1:0]       best_id_reg, best_id_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             out_id_reg, out_id_next;
    logic [63:0]            out_cost_reg, out_cost_next;
    logic [3:0]             out_step_reg, out_step_next;

    lcmcss_pkg::uop_t       uop;
    logic                   last_sub;
    logic                   sample_beat;
    logic                   out_free;

    // scratch memory and read registers
    logic signed [63:0] scr_mem [lcmcss_pkg::SLOTS];
    logic signed [63:0] rd_a_reg, rd_b_reg;
    logic [31:0]        a_rd_reg, e_rd_reg, p_rd_reg, xe_rd_reg, ell_rd_reg;
    logic               scr_we;
    logic signed [63:0] scr_wdata;
    logic [31:0]        tbl_word;
    logic [31:0]        x_sel;

    // shared multiplier
    logic               mul_start, mul_done;
    logic signed [63:0] mul_res;

    lcmcss_qmul u_qmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (rd_a_reg),
        .op_b    (rd_b_reg),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign uop         = lcmcss_pkg::prog_at(pc_reg);
    assign last_sub    = {1'b0, sub_reg} == (nsub_eff - 4'd1);
    assign s_tready    = state_reg == lcmcss_pkg::SQ_IDLE;
    assign sample_beat = s_tvalid && s_tready && s_tuser;
    assign out_free    = !out_valid_reg || m_tready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcmcss_pkg::SQ_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge aclk) begin
        pc_reg       <= pc_next;
        sub_reg      <= sub_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        best_id_reg  <= best_id_next;
        out_id_reg   <= out_id_next;
        out_cost_reg <= out_cost_next;
        out_step_reg <= out_step_next;
    end

    // operand fetch from scratch and tables
    always_ff @(posedge aclk) begin
        if (state_reg == lcmcss_pkg::SQ_FETCH) begin
            rd_a_reg   <= scr_mem[uop.ra];
            rd_b_reg   <= scr_mem[uop.rb];
            a_rd_reg   <= a_mem[{sub_reg, uop.el}];
            e_rd_reg   <= e_mem[{sub_reg, uop.el}];
            p_rd_reg   <= p_mem[{(uop.src == lcmcss_pkg::SRC_PN) ?
                                 n_reg[STEP_W-1:0] : k_reg, uop.el}];
            xe_rd_reg  <= xe_mem[{k_reg, uop.el[0]}];
            ell_rd_reg <= ell_mem[{k_reg, sub_reg, uop.el[0]}];
        end
    end

    // scratch write
    always_ff @(posedge aclk) begin
        if (scr_we) scr_mem[uop.dst] <= scr_wdata;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcmcss_pkg::SQ_IDLE:
                if (sample_beat) state_next = lcmcss_pkg::SQ_MOD;
            lcmcss_pkg::SQ_MOD:
                if (n_reg < len_eff) state_next = lcmcss_pkg::SQ_FETCH;
            lcmcss_pkg::SQ_FETCH:
                state_next = lcmcss_pkg::SQ_EXEC;
            lcmcss_pkg::SQ_EXEC: begin
                if (uop.kind == lcmcss_pkg::UOP_MAC)
                    state_next = lcmcss_pkg::SQ_MULW;
                else if (uop.kind == lcmcss_pkg::UOP_END && last_sub)
                    state_next = lcmcss_pkg::SQ_DONE;
                else
                    state_next = lcmcss_pkg::SQ_FETCH;
            end
            lcmcss_pkg::SQ_MULW:
                if (mul_done) state_next = lcmcss_pkg::SQ_FETCH;
            lcmcss_pkg::SQ_DONE:
                if (out_free) state_next = lcmcss_pkg::SQ_IDLE;
            default: state_next = lcmcss_pkg::SQ_IDLE;
        endcase
    end

    // table word for the current load micro-op
    always_comb begin
        case (uop.src)
            lcmcss_pkg::SRC_A:   tbl_word = a_rd_reg;
            lcmcss_pkg::SRC_E:   tbl_word = e_rd_reg;
            lcmcss_pkg::SRC_PN:  tbl_word = p_rd_reg;
            lcmcss_pkg::SRC_PC:  tbl_word = p_rd_reg;
            lcmcss_pkg::SRC_ELL: tbl_word = ell_rd_reg;
            default:             tbl_word = a_rd_reg;
        endcase
        x_sel = uop.el[0] ? x1_reg : x0_reg;
    end

    // datapath and outputs
    always_comb begin
        pc_next        = pc_reg;
        sub_next       = sub_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        best_id_next   = best_id_reg;
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_cost_next  = out_cost_reg;
        out_step_next  = out_step_reg;
        scr_we         = 1'b0;
        scr_wdata      = acc_reg;
        mul_start      = 1'b0;

        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        case (state_reg)
            lcmcss_pkg::SQ_IDLE: begin
                if (sample_beat) begin
                    k_next  = step_reg;
                    n_next  = {1'b0, step_reg} + 5'd1;
                    x0_next = in_x0;
                    x1_next = in_x1;
                end
            end
            // reduce k+1 modulo the cycle length, one subtract a cycle
            lcmcss_pkg::SQ_MOD: begin
                if (n_reg >= len_eff) begin
                    n_next = n_reg - len_eff;
                end else begin
                    step_next = (({1'b0, k_reg} + 5'd1) >= len_eff) ? '0 : k_reg + 1'b1;
                    pc_next   = '0;
                    sub_next  = '0;
                end
            end
            lcmcss_pkg::SQ_EXEC: begin
                case (uop.kind)
                    lcmcss_pkg::UOP_LD: begin
                        scr_we    = 1'b1;
                        scr_wdata = {{32{tbl_word[31]}}, tbl_word};
                        pc_next   = pc_reg + 1'b1;
                    end
                    lcmcss_pkg::UOP_LX: begin
                        scr_we    = 1'b1;
                        scr_wdata = {{32{x_sel[31]}}, x_sel}
                                  - {{32{xe_rd_reg[31]}}, xe_rd_reg};
                        pc_next   = pc_reg + 1'b1;
                    end
                    lcmcss_pkg::UOP_MAC: mul_start = 1'b1;
                    lcmcss_pkg::UOP_ADD: begin
                        acc_next = lcmcss_pkg::sat_add(uop.clr ? 64'sd0 : acc_reg, rd_a_reg);
                        pc_next  = pc_reg + 1'b1;
                    end
                    lcmcss_pkg::UOP_SUB: begin
                        acc_next = lcmcss_pkg::sat_sub(acc_reg, rd_a_reg);
                        pc_next  = pc_reg + 1'b1;
                    end
                    lcmcss_pkg::UOP_ST: begin
                        scr_we    = 1'b1;
                        scr_wdata = acc_reg;
                        pc_next   = pc_reg + 1'b1;
                    end
                    lcmcss_pkg::UOP_END: begin
                        // keep the lowest cost, first index wins ties
                        if (sub_reg == '0 || acc_reg < best_reg) begin
                            best_next    = acc_reg;
                            best_id_next = sub_reg;
                        end
                        pc_next  = lcmcss_pkg::BODY_START;
                        sub_next = sub_reg + 1'b1;
                    end
                    default: pc_next = pc_reg;
                endcase
            end
            lcmcss_pkg::SQ_MULW: begin
                if (mul_done) begin
                    acc_next = lcmcss_pkg::sat_add(uop.clr ? 64'sd0 : acc_reg, mul_res);
                    pc_next  = pc_reg + 1'b1;
                end
            end
            lcmcss_pkg::SQ_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_id_next    = 3'(best_id_reg);
                    out_cost_next  = best_reg;
                    out_step_next  = 4'(k_reg);
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_step_reg, out_cost_reg, out_id_reg};

endmodule

FILE: hdl/lcmcss_chk.sv
// port-level checker for the switch selector, bound to the top level
`include "limit_cycle_min_cost_switch_select_macros.svh"

module lcmcss_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lcmcss_pkg::M_TDATA_W-1:0]   m_tdata
);

    // a stalled result stays offered
    `LCMCSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    // a stalled result keeps its value
    `LCMCSS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    // a sample beat makes the block busy
    `LCMCSS_ASSERT_NEXT(a_sample_busy, s_tvalid && s_tready && s_tuser, !s_tready, "sample did not start work")
    // load beats never stall the input
    `LCMCSS_ASSERT_NEXT(a_load_free, s_tvalid && s_tready && !s_tuser, s_tready, "load beat stalled the input")

endmodule

bind limit_cycle_min_cost_switch_select lcmcss_chk u_lcmcss_chk (.*);

FILE: tb/limit_cycle_min_cost_switch_select_tb.sv
// self-checking testbench for the limit-cycle minimum-cost switch selector
`timescale 1ns / 1ps

module limit_cycle_min_cost_switch_select_tb;

    localparam longint SAT_HI = 64'sh7fff_ffff_ffff_ffff;
    localparam longint SAT_LO = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [2:0]         chosen;
        logic signed [63:0] cost;
        logic [3:0]         step;
    } choice_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [lcmcss_pkg::S_TDATA_W-1:0]      s_tdata;
    logic                                  s_tuser;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [lcmcss_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [lcmcss_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [lcmcss_pkg::CFG_DATA_W-1:0]     cfg_data;

    bit idle_en;
    bit hold_req;
    int hold_cnt;

    // predicts the selector and checks each result beat against it
    class switch_cost_scoreboard;
        int      errors;
        choice_t pending_choices[$];
        int      nsub_reg;
        int      len_reg;
        logic [3:0] step_ctr;
        longint  a_tab[32];
        longint  e_tab[32];
        longint  p_tab[64];
        longint  xe_tab[32];
        longint  ell_tab[256];
        longint  xi0, xi1;

        function new();
            errors   = 0;
            nsub_reg = 1;
            len_reg  = 1;
            step_ctr = '0;
            foreach (a_tab[j]) a_tab[j] = 0;
            foreach (e_tab[j]) e_tab[j] = 0;
            foreach (p_tab[j]) p_tab[j] = 0;
            foreach (xe_tab[j]) xe_tab[j] = 0;
            foreach (ell_tab[j]) ell_tab[j] = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function longint clip_add(longint x, longint y);
            logic signed [64:0] s;
            s = 65'(x) + 65'(y);
            if (s[64] != s[63]) return s[64] ? SAT_LO : SAT_HI;
            return s[63:0];
        endfunction

        function longint clip_sub(longint x, longint y);
            logic signed [64:0] s;
            s = 65'(x) - 65'(y);
            if (s[64] != s[63]) return s[64] ? SAT_LO : SAT_HI;
            return s[63:0];
        endfunction

        // exact product, floor shift by 16, clip to 64 bits
        function longint qprod(longint x, longint y);
            logic signed [127:0] px, py, p;
            px = x;
            py = y;
            p  = (px * py) >>> 16;
            if (p[127:63] == '0 || p[127:63] == '1) return p[63:0];
            return p[127] ? SAT_LO : SAT_HI;
        endfunction

        function longint dot(longint a0, longint b0, longint a1, longint b1);
            return clip_add(qprod(a0, b0), qprod(a1, b1));
        endfunction

        function longint sub_cost(int i, int k, int n);
            longint a[4], e[4], pn[4], pc[4], l[2];
            longint t1[4], t2[4], m[4], ee[4], q[2], s[2], r[2], c, f0, f1, f2;
            for (int j = 0; j < 4; j++) begin
                a[j]  = a_tab[i*4+j];
                e[j]  = e_tab[i*4+j];
                pn[j] = p_tab[n*4+j];
                pc[j] = p_tab[k*4+j];
            end
            l[0] = ell_tab[(k*8+i)*2];
            l[1] = ell_tab[(k*8+i)*2+1];
            t1[0] = dot(a[0], pn[0], a[2], pn[2]);
            t1[1] = dot(a[0], pn[1], a[2], pn[3]);
            t1[2] = dot(a[1], pn[0], a[3], pn[2]);
            t1[3] = dot(a[1], pn[1], a[3], pn[3]);
            t2[0] = dot(t1[0], a[0], t1[1], a[2]);
            t2[1] = dot(t1[0], a[1], t1[1], a[3]);
            t2[2] = dot(t1[2], a[0], t1[3], a[2]);
            t2[3] = dot(t1[2], a[1], t1[3], a[3]);
            ee[0] = dot(e[0], e[0], e[2], e[2]);
            ee[1] = dot(e[0], e[1], e[2], e[3]);
            ee[2] = dot(e[1], e[0], e[3], e[2]);
            ee[3] = dot(e[1], e[1], e[3], e[3]);
            for (int j = 0; j < 4; j++) m[j] = clip_add(clip_sub(t2[j], pc[j]), ee[j]);
            q[0] = dot(t1[0], l[0], t1[1], l[1]);
            q[1] = dot(t1[2], l[0], t1[3], l[1]);
            s[0] = dot(l[0], pn[0], l[1], pn[2]);
            s[1] = dot(l[0], pn[1], l[1], pn[3]);
            r[0] = dot(s[0], a[0], s[1], a[2]);
            r[1] = dot(s[0], a[1], s[1], a[3]);
            c    = dot(s[0], l[0], s[1], l[1]);
            f0 = clip_add(dot(xi0, m[0], xi1, m[2]), r[0]);
            f1 = clip_add(dot(xi0, m[1], xi1, m[3]), r[1]);
            f2 = clip_add(dot(xi0, q[0], xi1, q[1]), c);
            return clip_add(dot(f0, xi0, f1, xi1), f2);
        endfunction

        function void write_reg(lcmcss_pkg::cfg_reg_t idx, logic [7:0] val);
            if (idx == lcmcss_pkg::CFG_NUM_SUBSYSTEMS) nsub_reg = int'(val[3:0]);
            else if (idx == lcmcss_pkg::CFG_CYCLE_LENGTH) len_reg = int'(val[4:0]);
        endfunction

        function void note_input(logic kind, logic [lcmcss_pkg::S_TDATA_W-1:0] d);
            logic [2:0] sel;
            int ent, sub, el, nsub, len, k, n;
            longint w, best, cost;
            choice_t ch;
            sel = d[2:0];
            ent = int'(d[6:3]);
            sub = int'(d[9:7]);
            el  = int'(d[11:10]);
            w   = longint'($signed(d[43:12]));
            if (!kind) begin
                case (sel)
                    lcmcss_pkg::TBL_A:   if (ent < 8) a_tab[ent*4+el] = w;
                    lcmcss_pkg::TBL_E:   if (ent < 8) e_tab[ent*4+el] = w;
                    lcmcss_pkg::TBL_P:   p_tab[ent*4+el] = w;
                    lcmcss_pkg::TBL_XE:  if (el < 2) xe_tab[ent*2+el] = w;
                    lcmcss_pkg::TBL_ELL: if (el < 2) ell_tab[(ent*8+sub)*2+el] = w;
                    default: ;
                endcase
                return;
            end
            nsub = (nsub_reg < 1) ? 1 : (nsub_reg > 8) ? 8 : nsub_reg;
            len  = (len_reg < 1) ? 1 : (len_reg > 16) ? 16 : len_reg;
            k    = int'(step_ctr);
            n    = (k + 1) % len;
            xi0  = longint'($signed(d[75:44])) - xe_tab[k*2];
            xi1  = longint'($signed(d[107:76])) - xe_tab[k*2+1];
            best = 0;
            ch.chosen = '0;
            for (int i = 0; i < nsub; i++) begin
                cost = sub_cost(i, k, n);
                if (i == 0 || cost < best) begin
                    best = cost;
                    ch.chosen = 3'(i);
                end
            end
            step_ctr = (k + 1 >= len) ? 4'd0 : 4'(k + 1);
            ch.cost = best;
            ch.step = 4'(k);
            pending_choices.push_back(ch);
        endfunction

        task check_result(logic [lcmcss_pkg::M_TDATA_W-1:0] d);
            choice_t ch;
            if (pending_choices.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            ch = pending_choices.pop_front();
            if (d[2:0] !== ch.chosen)
                report($sformatf("chosen %0d, expected %0d", d[2:0], ch.chosen));
            if ($signed(d[66:3]) !== ch.cost)
                report($sformatf("cost %0d, expected %0d", $signed(d[66:3]), ch.cost));
            if (d[70:67] !== ch.step)
                report($sformatf("step %0d, expected %0d", d[70:67], ch.step));
        endtask
    endclass

    switch_cost_scoreboard sb;

    limit_cycle_min_cost_switch_select i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result beats are checked at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver readiness, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 12000;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_en && $urandom_range(0, 99) < 7);
        end
    end

    // table word: mostly small values, some extremes, some full range
    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2: return $urandom;
            default: return 32'($urandom_range(0, 262143)) - 32'd131072;
        endcase
    endfunction

    function automatic logic [lcmcss_pkg::S_TDATA_W-1:0] load_beat(logic [2:0] sel,
                                                                   logic [3:0] ent,
                                                                   logic [2:0] sub,
                                                                   logic [1:0] el,
                                                                   logic [31:0] val);
        logic [lcmcss_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[2:0]   = sel;
        d[6:3]   = ent;
        d[9:7]   = sub;
        d[11:10] = el;
        d[43:12] = val;
        return d;
    endfunction

    function automatic logic [lcmcss_pkg::S_TDATA_W-1:0] sample_beat(logic [31:0] x0,
                                                                     logic [31:0] x1);
        logic [lcmcss_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[11:0]   = 12'($urandom);
        d[43:12]  = $urandom;
        d[75:44]  = x0;
        d[107:76] = x1;
        return d;
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic send_beat(logic kind, logic [lcmcss_pkg::S_TDATA_W-1:0] d);
        if (idle_en && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, d);
        @(negedge aclk);
    endtask

    // stop offering and wait until every result has come and loads settled
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_choices.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(lcmcss_pkg::cfg_reg_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_load();
        logic [2:0] sel;
        logic [3:0] ent;
        logic [1:0] el;
        sel = 3'($urandom_range(0, 4));
        ent = (sel <= lcmcss_pkg::TBL_E) ? 4'($urandom_range(0, 7))
                                         : 4'($urandom_range(0, 15));
        el  = (sel >= lcmcss_pkg::TBL_XE) ? 2'($urandom_range(0, 1))
                                          : 2'($urandom_range(0, 3));
        send_beat(1'b0, load_beat(sel, ent, 3'($urandom), el, rnd_word()));
    endtask

    // address that the block must ignore
    task automatic ignored_load();
        case ($urandom_range(0, 3))
            0: send_beat(1'b0, load_beat(3'($urandom_range(5, 7)), 4'($urandom),
                                         3'($urandom), 2'($urandom), $urandom));
            1: send_beat(1'b0, load_beat(lcmcss_pkg::TBL_A, 4'($urandom_range(8, 15)),
                                         3'($urandom), 2'($urandom), $urandom));
            2: send_beat(1'b0, load_beat(lcmcss_pkg::TBL_E, 4'($urandom_range(8, 15)),
                                         3'($urandom), 2'($urandom), $urandom));
            default: send_beat(1'b0, load_beat(3'($urandom_range(3, 4)), 4'($urandom),
                                               3'($urandom), 2'($urandom_range(2, 3)),
                                               $urandom));
        endcase
    endtask

    function automatic logic [7:0] pick_nsub();
        case ($urandom_range(0, 11))
            0: return 8'd8;
            1: return 8'd0;
            2: return {4'($urandom), 4'($urandom_range(9, 15))};
            default: return 8'($urandom_range(1, 3));
        endcase
    endfunction

    // stimulus
    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = lcmcss_pkg::CFG_NUM_SUBSYSTEMS;
        cfg_data  = '0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        hold_cnt  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // fill every table entry once so no unwritten word is ever read
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 4; j++) begin
                send_beat(1'b0, load_beat(lcmcss_pkg::TBL_A, 4'(i), 3'd0, 2'(j), rnd_word()));
                send_beat(1'b0, load_beat(lcmcss_pkg::TBL_E, 4'(i), 3'd0, 2'(j), rnd_word()));
            end
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++)
                send_beat(1'b0, load_beat(lcmcss_pkg::TBL_P, 4'(i), 3'd0, 2'(j), rnd_word()));
            for (int j = 0; j < 2; j++) begin
                send_beat(1'b0, load_beat(lcmcss_pkg::TBL_XE, 4'(i), 3'd0, 2'(j), rnd_word()));
                for (int s = 0; s < 8; s++)
                    send_beat(1'b0, load_beat(lcmcss_pkg::TBL_ELL, 4'(i), 3'(s), 2'(j),
                                              rnd_word()));
            end
        end

        // directed: reset settings, extreme states and extreme words
        send_beat(1'b1, sample_beat(32'h8000_0000, 32'h7fff_ffff));
        send_beat(1'b1, sample_beat(32'h7fff_ffff, 32'h8000_0000));
        drain();
        write_reg(lcmcss_pkg::CFG_NUM_SUBSYSTEMS, 8'd8);
        write_reg(lcmcss_pkg::CFG_CYCLE_LENGTH, 8'd16);
        send_beat(1'b0, load_beat(lcmcss_pkg::TBL_A, 4'd7, 3'd0, 2'd3, 32'h7fff_ffff));
        send_beat(1'b0, load_beat(lcmcss_pkg::TBL_E, 4'd0, 3'd0, 2'd0, 32'h8000_0000));
        send_beat(1'b0, load_beat(lcmcss_pkg::TBL_ELL, 4'd15, 3'd7, 2'd1, 32'h7fff_ffff));
        send_beat(1'b0, load_beat(lcmcss_pkg::TBL_XE, 4'd1, 3'd0, 2'd0, 32'h8000_0000));
        send_beat(1'b1, sample_beat(32'h0, 32'h0));
        send_beat(1'b1, sample_beat(32'hffff_ffff, 32'h0001_0000));
        repeat (4) ignored_load();
        send_beat(1'b1, sample_beat($urandom, $urandom));
        drain();
        // out-of-range counts and a length lowered under the counter
        write_reg(lcmcss_pkg::CFG_NUM_SUBSYSTEMS, 8'd0);
        write_reg(lcmcss_pkg::CFG_CYCLE_LENGTH, 8'd0);
        send_beat(1'b1, sample_beat($urandom, $urandom));
        send_beat(1'b1, sample_beat($urandom, $urandom));
        drain();
        write_reg(lcmcss_pkg::CFG_NUM_SUBSYSTEMS, 8'd15);
        write_reg(lcmcss_pkg::CFG_CYCLE_LENGTH, 8'd31);
        send_beat(1'b1, sample_beat($urandom, $urandom));
        send_beat(1'b1, sample_beat($urandom, $urandom));
        drain();

        // random phases, settings changed only while idle
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(lcmcss_pkg::CFG_NUM_SUBSYSTEMS, pick_nsub());
            write_reg(lcmcss_pkg::CFG_CYCLE_LENGTH, 8'($urandom_range(0, 31)));
            idle_en = (ph != 3);
            if (ph == 5) hold_req = 1'b1;
            for (int n = 0; n < 120; n++) begin
                case ($urandom_range(0, 19))
                    0, 1:          ignored_load();
                    2, 3, 4, 5, 6: send_beat(1'b1, sample_beat(rnd_word(), rnd_word()));
                    default:       random_load();
                endcase
            end
            drain();
        end
        idle_en = 1'b1;

        // nothing left pending; allow a full evaluation time for strays
        repeat (4500) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_choices.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
